[hw/rtl/triangle_spherical_angle_bounds_top_assert.svh]
// assertion macros for the triangle angle bounds block
`ifndef TRIANGLE_SPHERICAL_ANGLE_BOUNDS_TOP_ASSERT_SVH
`define TRIANGLE_SPHERICAL_ANGLE_BOUNDS_TOP_ASSERT_SVH

// implication checked every clock outside reset
`define TSAB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define TSAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/tsab_pkg.sv]
package tsab_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // internal datapath widths
  localparam int MAG_W  = 32;
  localparam int CW_W   = 66;
  localparam int ACC_W  = 34;
  localparam int OUT_W  = 16;
  localparam int SQ_W   = 33;
  // sqrt digit steps, one 2-bit digit per cell
  localparam int SQRT_STEPS = 33;

  // sign code of y
  typedef enum logic [1:0] {
    SGN_ZERO = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sgn_t;

  // arctangent table, 2^-32 turn per unit
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] tab [32];
    tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
            32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
            32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
            32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};
    return tab[i];
  endfunction

endpackage

[hw/rtl/tsab_sqrt_cell.sv]
// one digit of the restoring square root of one vertex
module tsab_sqrt_cell (
  input  logic                        clk,
  input  logic [2*tsab_pkg::SQ_W-1:0] rem_in,
  input  logic [2*tsab_pkg::SQ_W-1:0] root_in,
  input  logic [2*tsab_pkg::SQ_W-1:0] bit_in,
  output logic [2*tsab_pkg::SQ_W-1:0] rem,
  output logic [2*tsab_pkg::SQ_W-1:0] root
);
  import tsab_pkg::*;

  logic [2*SQ_W-1:0] trial;

  // try subtract of root plus bit
  assign trial = root_in + bit_in;

  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem  <= rem_in - trial;
      root <= (root_in >> 1) + bit_in;
    end else begin
      rem  <= rem_in;
      root <= root_in >> 1;
    end
  end

endmodule

[hw/rtl/tsab_cordic_cell.sv]
// one cordic vectoring stage, rotation index fixed per cell
module tsab_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic signed [tsab_pkg::CW_W-1:0]  x_in,
  input  logic signed [tsab_pkg::CW_W-1:0]  y_in,
  input  logic signed [tsab_pkg::ACC_W-1:0] acc_in,
  output logic signed [tsab_pkg::CW_W-1:0]  x,
  output logic signed [tsab_pkg::CW_W-1:0]  y,
  output logic signed [tsab_pkg::ACC_W-1:0] acc
);
  import tsab_pkg::*;

  logic signed [CW_W-1:0]  dx;
  logic signed [CW_W-1:0]  dy;
  logic signed [ACC_W-1:0] ang;

  // floor shifts and table angle
  assign dx  = y_in >>> IDX;
  assign dy  = x_in >>> IDX;
  assign ang = signed'({2'b00, atan_entry(IDX)});

  always_ff @(posedge clk) begin
    if (!y_in[CW_W-1]) begin
      x   <= x_in + dx;
      y   <= y_in - dy;
      acc <= acc_in + ang;
    end else begin
      x   <= x_in - dx;
      y   <= y_in + dy;
      acc <= acc_in - ang;
    end
  end

endmodule

[hw/rtl/tsab_atan_unit.sv]
// first-quadrant atan2(b, a): normalize, cordic chain, round;
// inputs registered, then the cordic cell chain, then a registered output; mode bits ride alongside
module tsab_atan_unit #(
  parameter int ANGLE_BITS    = tsab_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = tsab_pkg::CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic [tsab_pkg::SQ_W-1:0] a,
  input  logic [tsab_pkg::SQ_W-1:0] b,
  output logic [ANGLE_BITS-1:0]     angle
);
  import tsab_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int LZ_W = 6;

  logic [SQ_W-1:0]  mx;
  logic [LZ_W-1:0]  lz;
  logic [SQ_W-1:0]  a_r;
  logic [SQ_W-1:0]  b_r;
  logic [LZ_W-1:0]  lz_r;
  logic             bz_r;
  logic             az_r;
  logic signed [CW_W-1:0]  xs [NSTG+1];
  logic signed [CW_W-1:0]  ys [NSTG+1];
  logic signed [ACC_W-1:0] accs [NSTG+1];
  logic [NSTG:0]    bz_d;
  logic [NSTG:0]    az_d;
  logic signed [ACC_W-1:0] acc_c;
  logic [ACC_W-1:0] acc_rnd;

  // leading zero count of the larger operand
  assign mx = (a > b) ? a : b;
  always_comb begin
    lz = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (mx[i]) lz = LZ_W'(SQ_W - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a;
    b_r  <= b;
    lz_r <= lz;
    bz_r <= (b == '0);
    az_r <= (a == '0);
  end

  // shift so larger operand reaches bit 39
  always_comb begin
    logic [CW_W-1:0] ax;
    logic [CW_W-1:0] bx;
    ax = CW_W'(a_r);
    bx = CW_W'(b_r);
    ax = ax << (LZ_W'(39 - (SQ_W - 1)) + lz_r);
    bx = bx << (LZ_W'(39 - (SQ_W - 1)) + lz_r);
    xs[0] = signed'(ax);
    ys[0] = signed'(bx);
    accs[0] = '0;
  end

  assign bz_d[0] = bz_r;
  assign az_d[0] = az_r;

  // chain of vectoring cells
  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    tsab_cordic_cell #(.IDX(g)) u_cell (
      .clk(clk), .x_in(xs[g]), .y_in(ys[g]), .acc_in(accs[g]),
      .x(xs[g+1]), .y(ys[g+1]), .acc(accs[g+1])
    );
    always_ff @(posedge clk) begin
      bz_d[g+1] <= bz_d[g];
      az_d[g+1] <= az_d[g];
    end
  end

  // clamp and round half up
  always_comb begin
    acc_c = accs[NSTG];
    if (acc_c < 0) acc_c = '0;
    if (acc_c > signed'(ACC_W'(1) << 30)) acc_c = signed'(ACC_W'(1) << 30);
    acc_rnd = (ACC_W'(acc_c) + (ACC_W'(1) << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (bz_d[NSTG]) angle <= '0;
    else if (az_d[NSTG]) angle <= ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    else angle <= acc_rnd[ANGLE_BITS-1:0];
  end

endmodule

[hw/rtl/tsab_vertex.sv]
// angles of one vertex: sign split, normalize, sqrt chain, two atan units
module tsab_vertex #(
  parameter int COORD_WIDTH   = tsab_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_BITS    = tsab_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = tsab_pkg::CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic [COORD_WIDTH-1:0] cx,
  input  logic [COORD_WIDTH-1:0] cy,
  input  logic [COORD_WIDTH-1:0] cz,
  output logic [ANGLE_BITS-1:0]  theta,
  output logic [ANGLE_BITS-1:0]  phi,
  output tsab_pkg::sgn_t         ysgn
);
  import tsab_pkg::*;

  localparam int NSTG   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int PRE    = (COORD_WIDTH > 32) ? COORD_WIDTH - 32 : 0;
  localparam int ATLAT  = NSTG + 2;
  localparam int SQ2    = 2 * SQ_W;
  localparam int LZ_W   = 6;

  logic [COORD_WIDTH-1:0] mxw;
  logic [COORD_WIDTH-1:0] myw;
  logic [COORD_WIDTH-1:0] mzw;
  logic [MAG_W-1:0] mx0;
  logic [MAG_W-1:0] my0;
  logic [MAG_W-1:0] mz0;
  logic [MAG_W-1:0] mm;
  logic [LZ_W-1:0]  lz;
  logic [MAG_W-1:0] nx;
  logic [MAG_W-1:0] ny;
  logic [MAG_W-1:0] nz;
  logic             nxs;
  logic             nzs;
  sgn_t             nys;
  logic [SQ2-1:0]   sumsq;
  logic [SQ2-1:0]   sq_a;
  logic [SQ2-1:0]   sq_b;
  logic [MAG_W-1:0] px;
  logic [MAG_W-1:0] py;
  logic [MAG_W-1:0] pz;
  logic             pxs;
  logic             pzs;
  sgn_t             pys;
  logic [SQ2-1:0]   rems  [SQRT_STEPS+1];
  logic [SQ2-1:0]   roots [SQRT_STEPS+1];
  logic [MAG_W-1:0] zd    [SQRT_STEPS+1];
  logic [SQRT_STEPS+ATLAT:0] xsd;
  logic [SQRT_STEPS+ATLAT:0] zsd;
  sgn_t             ysd   [SQRT_STEPS+ATLAT+1];
  logic [ANGLE_BITS-1:0] t_raw;
  logic [ANGLE_BITS-1:0] p_raw;
  logic [ANGLE_BITS-1:0] p_raw_d [SQRT_STEPS+1];

  // magnitudes
  assign mxw = cx[COORD_WIDTH-1] ? (~cx + 1'b1) : cx;
  assign myw = cy[COORD_WIDTH-1] ? (~cy + 1'b1) : cy;
  assign mzw = cz[COORD_WIDTH-1] ? (~cz + 1'b1) : cz;
  assign mx0 = MAG_W'(mxw >> PRE);
  assign my0 = MAG_W'(myw >> PRE);
  assign mz0 = MAG_W'(mzw >> PRE);

  // common normalize so the largest reaches bit 30, or stays at bit 31 if already there
  always_comb begin
    mm = mx0 | my0 | mz0;
    lz = '0;
    for (int i = 0; i < 31; i++) begin
      if (mm[i]) lz = LZ_W'(30 - i);
    end
    if (mm[31]) lz = '0;
  end

  always_ff @(posedge clk) begin
    nx  <= mx0 << lz;
    ny  <= my0 << lz;
    nz  <= mz0 << lz;
    nxs <= cx[COORD_WIDTH-1];
    nzs <= cz[COORD_WIDTH-1];
    nys <= (cy == '0) ? SGN_ZERO : (cy[COORD_WIDTH-1] ? SGN_NEG : SGN_POS);
  end

  // squares, one multiplier each then a register
  always_ff @(posedge clk) begin
    sq_a <= SQ2'(nx) * SQ2'(nx);
    sq_b <= SQ2'(ny) * SQ2'(ny);
    px   <= nx;
    py   <= ny;
    pz   <= nz;
    pxs  <= nxs;
    pzs  <= nzs;
    pys  <= nys;
  end

  assign sumsq    = sq_a + sq_b;
  assign rems[0]  = sumsq;
  assign roots[0] = '0;
  assign zd[0]    = pz;
  assign xsd[0]   = pxs;
  assign zsd[0]   = pzs;
  assign ysd[0]   = pys;

  // square root chain
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    tsab_sqrt_cell u_cell (
      .clk(clk), .rem_in(rems[g]), .root_in(roots[g]),
      .bit_in(SQ2'(1) << (2 * (SQRT_STEPS - 1 - g))),
      .rem(rems[g+1]), .root(roots[g+1])
    );
    always_ff @(posedge clk) begin
      zd[g+1] <= zd[g];
    end
  end

  // delay lines for the signs
  for (genvar g = 0; g < SQRT_STEPS + ATLAT; g++) begin : g_sdly
    always_ff @(posedge clk) begin
      xsd[g+1] <= xsd[g];
      zsd[g+1] <= zsd[g];
      ysd[g+1] <= ysd[g];
    end
  end

  tsab_atan_unit #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_theta (
    .clk(clk), .a(SQ_W'(zd[SQRT_STEPS])), .b(SQ_W'(roots[SQRT_STEPS])), .angle(t_raw)
  );

  tsab_atan_unit #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_phi (
    .clk(clk), .a(SQ_W'(px)), .b(SQ_W'(py)), .angle(p_raw)
  );

  // phi finishes early; align with theta
  assign p_raw_d[0] = p_raw;
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_pdly
    always_ff @(posedge clk) begin
      p_raw_d[g+1] <= p_raw_d[g];
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    logic [ANGLE_BITS-1:0] p;
    logic [ANGLE_BITS-1:0] half;
    half = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    p = p_raw_d[SQRT_STEPS];
    if (xsd[SQRT_STEPS+ATLAT]) p = half - p;
    if (ysd[SQRT_STEPS+ATLAT] == SGN_NEG) p = ANGLE_BITS'(0) - p;
    phi   <= p;
    theta <= zsd[SQRT_STEPS+ATLAT] ? (half - t_raw) : t_raw;
    ysgn  <= ysd[SQRT_STEPS+ATLAT];
  end

endmodule

[hw/rtl/triangle_spherical_angle_bounds_top.sv]
// a request passes the vertex pipeline registers, the 33-cell square root chain
//   and the cordic cell chain (16 cordic stages) before the result queue
// throughput: one triangle per cycle; the pipeline never stalls, a 64-entry
//   result queue absorbs output stalls and credits hold off input when it fills
// reset: rst clears the pipeline valid bits, queue pointers, count and out_valid, refills credits
module triangle_spherical_angle_bounds_top #(
  parameter int COORD_WIDTH   = tsab_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_BITS    = tsab_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = tsab_pkg::CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] v0_x,
  input  logic [COORD_WIDTH-1:0] v0_y,
  input  logic [COORD_WIDTH-1:0] v0_z,
  input  logic [COORD_WIDTH-1:0] v1_x,
  input  logic [COORD_WIDTH-1:0] v1_y,
  input  logic [COORD_WIDTH-1:0] v1_z,
  input  logic [COORD_WIDTH-1:0] v2_x,
  input  logic [COORD_WIDTH-1:0] v2_y,
  input  logic [COORD_WIDTH-1:0] v2_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            theta_min,
  output logic [15:0]            theta_max,
  output logic [15:0]            phi_low,
  output logic [15:0]            phi_high,
  output logic                   phi_wraps
);
  import tsab_pkg::*;
  `include "triangle_spherical_angle_bounds_top_assert.svh"

  localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int LAT  = SQRT_STEPS + NSTG + 5;
  localparam int FIFO_D = 64;
  localparam int CNT_W  = $clog2(FIFO_D + 1);
  localparam int AW     = $clog2(FIFO_D);
  localparam int RW     = 4 * OUT_W + 1;

  logic [ANGLE_BITS-1:0] th [3];
  logic [ANGLE_BITS-1:0] ph [3];
  sgn_t                  ys [3];
  logic [LAT-1:0]        vld;
  logic [CNT_W-1:0]      credit;
  logic [CNT_W-1:0]      count;
  logic [AW-1:0]         wptr;
  logic [AW-1:0]         rptr;
  logic [RW-1:0]         res;
  logic [RW-1:0]         fifo [FIFO_D];
  logic                  acc_in;
  logic                  acc_out;
  logic                  pop;

  // free-running pipeline; credits bound results in flight to the queue depth
  assign acc_in   = in_valid && in_ready;
  assign acc_out  = out_valid && out_ready;
  assign in_ready = (credit != '0);

  tsab_vertex #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_BITS(ANGLE_BITS),
                .CORDIC_STAGES(CORDIC_STAGES)) u_v0 (
    .clk(clk), .cx(v0_x), .cy(v0_y), .cz(v0_z), .theta(th[0]), .phi(ph[0]), .ysgn(ys[0]));
  tsab_vertex #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_BITS(ANGLE_BITS),
                .CORDIC_STAGES(CORDIC_STAGES)) u_v1 (
    .clk(clk), .cx(v1_x), .cy(v1_y), .cz(v1_z), .theta(th[1]), .phi(ph[1]), .ysgn(ys[1]));
  tsab_vertex #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_BITS(ANGLE_BITS),
                .CORDIC_STAGES(CORDIC_STAGES)) u_v2 (
    .clk(clk), .cx(v2_x), .cy(v2_y), .cz(v2_z), .theta(th[2]), .phi(ph[2]), .ysgn(ys[2]));

  // min, max and wrap decision
  always_comb begin
    logic [ANGLE_BITS-1:0] tmn, tmx, pmn, pmx;
    logic w;
    tmn = th[0]; tmx = th[0]; pmn = ph[0]; pmx = ph[0];
    for (int k = 1; k < 3; k++) begin
      if (th[k] < tmn) tmn = th[k];
      if (th[k] > tmx) tmx = th[k];
      if (ph[k] < pmn) pmn = ph[k];
      if (ph[k] > pmx) pmx = ph[k];
    end
    w = !(ys[0] == ys[1] && ys[1] == ys[2]) &&
        (pmx > (ANGLE_BITS'(1) << (ANGLE_BITS - 1)));
    res = {OUT_W'(tmn), OUT_W'(tmx), w ? OUT_W'(pmx) : OUT_W'(pmn),
           w ? OUT_W'(pmn) : OUT_W'(pmx), w};
  end

  // valid tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], acc_in};
  end

  // result queue
  assign pop = (count != '0) && (!out_valid || out_ready);
  always_ff @(posedge clk) begin
    if (vld[LAT-1]) fifo[wptr] <= res;
    if (pop) {theta_min, theta_max, phi_low, phi_high, phi_wraps} <= fifo[rptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0; out_valid <= 1'b0;
      credit <= CNT_W'(FIFO_D);
    end else begin
      if (vld[LAT-1]) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + CNT_W'(vld[LAT-1]) - CNT_W'(pop);
      if (pop) out_valid <= 1'b1;
      else if (acc_out) out_valid <= 1'b0;
      credit <= credit - CNT_W'(acc_in) + CNT_W'(acc_out);
    end
  end

  `TSAB_ASSERT_IMPL(a_fifo_no_overflow, vld[LAT-1], count != CNT_W'(FIFO_D))
  `TSAB_ASSERT_IMPL(a_pop_has_data, pop, count != '0)
  `TSAB_ASSERT_NEXT(a_accept_tracked, acc_in, vld[0])

endmodule

[sim/triangle_spherical_angle_bounds_top_test.sv]
`timescale 1ns / 1ps
module triangle_spherical_angle_bounds_top_test;
  import tsab_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = 55;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] theta_min;
    logic [15:0] theta_max;
    logic [15:0] phi_low;
    logic [15:0] phi_high;
    logic        phi_wraps;
  } bounds_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] crd [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] theta_min, theta_max, phi_low, phi_high;
  logic phi_wraps;

  bounds_t bounds_q[$];
  int errors = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  initial begin
    for (int k = 0; k < 9; k++) crd[k] = '0;
  end

  triangle_spherical_angle_bounds_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .v0_x(crd[0]), .v0_y(crd[1]), .v0_z(crd[2]),
    .v1_x(crd[3]), .v1_y(crd[4]), .v1_z(crd[5]),
    .v2_x(crd[6]), .v2_y(crd[7]), .v2_z(crd[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .theta_min(theta_min), .theta_max(theta_max),
    .phi_low(phi_low), .phi_high(phi_high), .phi_wraps(phi_wraps)
  );

  // floor shift right of a signed 64-bit value
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // first-quadrant arctangent of b over a, in 16-bit binary angle
  function automatic int unsigned cordic_angle(longint unsigned a, longint unsigned b);
    longint unsigned m;
    longint xa, yb, acc, dx, dy;
    if (b == 0) return 0;
    if (a == 0) return 1 << 14;
    m = (a > b) ? a : b;
    while (m < (64'd1 << 39)) begin
      a <<= 1;
      b <<= 1;
      m <<= 1;
    end
    xa = a;
    yb = b;
    acc = 0;
    for (int i = 0; i < 16; i++) begin
      dx = fshr(yb, i);
      dy = fshr(xa, i);
      if (yb >= 0) begin
        xa += dx; yb -= dy; acc += longint'(atan_entry(i));
      end else begin
        xa -= dx; yb += dy; acc -= longint'(atan_entry(i));
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
    return int'((acc + (64'sd1 << 15)) >>> 16);
  endfunction

  function automatic sgn_t sign_of(logic [CW-1:0] v);
    if (v == 0) return SGN_ZERO;
    return v[CW-1] ? SGN_NEG : SGN_POS;
  endfunction

  function automatic longint unsigned mag_of(logic [CW-1:0] v);
    logic [CW-1:0] n;
    n = v[CW-1] ? -v : v;
    return longint'(n);
  endfunction

  // spherical bounds of one triangle
  function automatic bounds_t triangle_bounds(logic [CW-1:0] c [9]);
    int unsigned th[3], ph[3], tmin, tmax, pmin, pmax, t;
    sgn_t ys[3];
    longint unsigned ax, ay, az, m, s;
    bounds_t r;
    for (int k = 0; k < 3; k++) begin
      ax = mag_of(c[3*k]);
      ay = mag_of(c[3*k+1]);
      az = mag_of(c[3*k+2]);
      m = ax;
      if (ay > m) m = ay;
      if (az > m) m = az;
      if (m != 0)
        while (m < (64'd1 << 30)) begin
          ax <<= 1; ay <<= 1; az <<= 1; m <<= 1;
        end
      s = isqrt64(ax * ax + ay * ay);
      th[k] = cordic_angle(az, s);
      if (sign_of(c[3*k+2]) == SGN_NEG) th[k] = 32768 - th[k];
      ph[k] = cordic_angle(ax, ay);
      if (sign_of(c[3*k]) == SGN_NEG) ph[k] = 32768 - ph[k];
      ys[k] = sign_of(c[3*k+1]);
      if (ys[k] == SGN_NEG) ph[k] = (65536 - ph[k]) & 16'hffff;
    end
    tmin = th[0]; tmax = th[0]; pmin = ph[0]; pmax = ph[0];
    for (int k = 1; k < 3; k++) begin
      if (th[k] < tmin) tmin = th[k];
      if (th[k] > tmax) tmax = th[k];
      if (ph[k] < pmin) pmin = ph[k];
      if (ph[k] > pmax) pmax = ph[k];
    end
    r.phi_wraps = 1'b0;
    if (!(ys[0] == ys[1] && ys[1] == ys[2]) && pmax > 32768) begin
      t = pmin; pmin = pmax; pmax = t;
      r.phi_wraps = 1'b1;
    end
    r.theta_min = tmin[15:0];
    r.theta_max = tmax[15:0];
    r.phi_low = pmin[15:0];
    r.phi_high = pmax[15:0];
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one request and record its expected bounds
  task automatic send_triangle(logic [CW-1:0] c [9], bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    for (int k = 0; k < 9; k++) crd[k] <= c[k];
    in_valid <= 1'b1;
    bounds_q.push_back(triangle_bounds(c));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receive side with random stalls
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    bounds_t e;
    if (!rst && out_valid && out_ready) begin
      if (bounds_q.size() == 0) begin
        $display("unexpected result");
        errors++;
      end else begin
        e = bounds_q.pop_front();
        if (theta_min !== e.theta_min) report("theta_min", theta_min, e.theta_min);
        if (theta_max !== e.theta_max) report("theta_max", theta_max, e.theta_max);
        if (phi_low !== e.phi_low) report("phi_low", phi_low, e.phi_low);
        if (phi_high !== e.phi_high) report("phi_high", phi_high, e.phi_high);
        if (phi_wraps !== e.phi_wraps) report("phi_wraps", phi_wraps, e.phi_wraps);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return CW'($signed($urandom_range(0, 64)) - 32);
      4: return CW'($urandom) >>> $urandom_range(0, 31);
      default: return CW'($urandom);
    endcase
  endfunction

  // origin, axes, extremes, the azimuth wrap cases and random mixes of special values
  task automatic test_directed();
    logic [CW-1:0] c [9];
    logic [CW-1:0] v [14];
    v = '{0, 1, -1, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, -32'sh0001_0000,
          32'h4000_0000, -32'sh4000_0000, 5, -5, 32'hffff_fffe, 32'h0000_ffff, 2};
    for (int k = 0; k < 9; k++) c[k] = '0;
    send_triangle(c, 1'b0);
    // z axis both ways, a point near the negative x axis
    c = '{0, 0, 100, 0, 0, -100, -7, 0, 3};
    send_triangle(c, 1'b0);
    // all coordinates at the extremes
    for (int k = 0; k < 9; k++) c[k] = 32'h8000_0000;
    send_triangle(c, 1'b0);
    for (int k = 0; k < 9; k++) c[k] = 32'h7fff_ffff;
    send_triangle(c, 1'b0);
    // crossing phi zero: tiny negative y near positive x axis
    c = '{32'h7fff_ffff, -1, 0, 1000, 1000, 0, 1000, 0, 5};
    send_triangle(c, 1'b0);
    c = '{32'h7fff_ffff, 1, 0, 32'h7fff_ffff, -1, 1, 1, -1, 0};
    send_triangle(c, 1'b0);
    c = '{-1, -1, -1, -1, 1, -1, -1, 0, -1};
    send_triangle(c, 1'b0);
    for (int n = 0; n < 16; n++) begin
      for (int k = 0; k < 9; k++) c[k] = v[$urandom_range(0, 13)];
      send_triangle(c, 1'b0);
    end
  endtask

  task automatic test_random(int count);
    logic [CW-1:0] c [9];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < 9; k++) c[k] = rand_coord();
      // often steer the triangle across the positive x axis
      if ($urandom_range(0, 3) == 0) begin
        c[0][CW-1] = 1'b0; c[3][CW-1] = 1'b0; c[6][CW-1] = 1'b0;
        c[1] = CW'($signed($urandom_range(0, 2000)) - 1000);
      end
      send_triangle(c, 1'b1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    // hold off until every result is back
    wait_drained();
    test_random(800);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tsab_pkg.sv
hw/rtl/tsab_sqrt_cell.sv
hw/rtl/tsab_cordic_cell.sv
hw/rtl/tsab_atan_unit.sv
hw/rtl/tsab_vertex.sv
hw/rtl/triangle_spherical_angle_bounds_top.sv
sim/triangle_spherical_angle_bounds_top_test.sv
